// ===== design/hts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hts_pkg;

  // Path codes
  localparam logic [1:0] PATH_NONE = 2'd0;
  localparam logic [1:0] PATH_ONE  = 2'd1;
  localparam logic [1:0] PATH_TWO  = 2'd2;

  // Saturation limit of the 4-bit confirm counters
  localparam logic [3:0] CNT_MAX = 4'd15;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_SWITCH_MARGIN  = 3'd0;
  localparam logic [2:0] REG_FORCE_DISTANCE = 3'd1;
  localparam logic [2:0] REG_FORCE_MARGIN   = 3'd2;
  localparam logic [2:0] REG_LOCK_ENTER     = 3'd3;
  localparam logic [2:0] REG_LOCK_EXIT      = 3'd4;
  localparam logic [2:0] REG_MIN_HOLD_MS    = 3'd5;
  localparam logic [2:0] REG_COOLDOWN_MS    = 3'd6;
  localparam logic [2:0] REG_UNLOCK_HOLD_MS = 3'd7;

  // Register reset values
  localparam logic [15:0] RST_SWITCH_MARGIN  = 16'd300;
  localparam logic [15:0] RST_FORCE_DISTANCE = 16'd2000;
  localparam logic [15:0] RST_FORCE_MARGIN   = 16'd1000;
  localparam logic [15:0] RST_LOCK_ENTER     = 16'd250;
  localparam logic [15:0] RST_LOCK_EXIT      = 16'd600;
  localparam logic [15:0] RST_MIN_HOLD_MS    = 16'd500;
  localparam logic [15:0] RST_COOLDOWN_MS    = 16'd500;
  localparam logic [15:0] RST_UNLOCK_HOLD_MS = 16'd0;

  typedef struct packed {
    logic [15:0] switch_margin;
    logic [15:0] force_distance;
    logic [15:0] force_margin;
    logic [15:0] lock_enter;
    logic [15:0] lock_exit;
    logic [15:0] min_hold_ms;
    logic [15:0] cooldown_ms;
    logic [15:0] unlock_hold_ms;
  } hts_cfg_t;

  // Overlap lock state
  typedef struct packed {
    logic        flag;
    logic [3:0]  enter_cnt;
    logic [3:0]  exit_cnt;
    logic [31:0] unlock_time;
    logic        unlock_set;
  } hts_lock_t;

  // Path selection state
  typedef struct packed {
    logic [1:0]  stable;
    logic [31:0] switch_time;
    logic [1:0]  pend_choice;
    logic [3:0]  pend_cnt;
  } hts_sel_t;

endpackage

`default_nettype wire

// ===== design/hysteretic_two_path_selector.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel    Dir  Beat                         Accepted when
// s_axis     in   one frame of path metrics    s_axis_tvalid_i && s_axis_tready_o
// m_axis     out  chosen path and lock state   m_axis_tvalid_o && m_axis_tready_i
// cfg        in   register write, 16 bit       cfg_we_i
//
// One result beat for every input beat; a frame sits in the input register and
// then in the result register. Throughput is one frame per cycle while the result
// register drains (m_axis_tready_i high): the lock and selection state update in the
// same cycle that a frame moves from the input register into the result register.
// Reset clears the control, lock and selection state and loads the register defaults; no clearing pass.
// A stalled result register holds the frame in the input register and drops
// s_axis_tready_o only when both are full.
module hysteretic_two_path_selector #(
  parameter int CONFIRM_SWITCH = 3,
  parameter int CONFIRM_ENTER  = 3,
  parameter int CONFIRM_EXIT   = 10,
  parameter int MIN_POINTS     = 5,
  parameter int LOCK_ENABLE    = 1
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // Input stream
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // tdata: time_ms[31:0], dist_one[47:32], dist_two[63:48], points_one[73:64],
  //        points_two[83:74], separation[99:84], zero pad[103:100]
  input  wire logic [103:0] s_axis_tdata_i,
  // tuser: found_one[0], found_two[1], separation_known[2]
  input  wire logic [2:0]   s_axis_tuser_i,
  // Result stream
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // tdata: chosen_path[1:0], locked[2], zero pad[7:3]
  output logic [7:0]        m_axis_tdata_o,
  // Configuration writes
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_idx_i,
  input  wire logic [15:0]  cfg_data_i
);

  hts_pkg::hts_cfg_t  cfg_q;
  hts_pkg::hts_lock_t lock_q;
  hts_pkg::hts_lock_t lock_d;
  hts_pkg::hts_sel_t  sel_q;
  hts_pkg::hts_sel_t  sel_mid;
  hts_pkg::hts_sel_t  sel_d;

  logic         in_valid_q;
  logic [103:0] in_data_q;
  logic [2:0]   in_user_q;
  logic         out_valid_q;
  logic [1:0]   out_path_q;
  logic         out_locked_q;

  logic         in_accept;
  logic         advance;
  logic         released;

  logic [31:0]  now;
  logic [15:0]  dist_one;
  logic [15:0]  dist_two;
  logic [9:0]   points_one;
  logic [9:0]   points_two;
  logic [15:0]  separation;
  logic         valid_one;
  logic         valid_two;

  // Move the held frame into the result register when that register is free or draining
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  assign now        = in_data_q[31:0];
  assign dist_one   = in_data_q[47:32];
  assign dist_two   = in_data_q[63:48];
  assign points_one = in_data_q[73:64];
  assign points_two = in_data_q[83:74];
  assign separation = in_data_q[99:84];

  // A path counts only when found with enough points
  assign valid_one = in_user_q[0] && (points_one >= 10'(MIN_POINTS));
  assign valid_two = in_user_q[1] && (points_two >= 10'(MIN_POINTS));

  hts_lock #(
    .CONFIRM_ENTER (CONFIRM_ENTER),
    .CONFIRM_EXIT  (CONFIRM_EXIT),
    .LOCK_ENABLE   (LOCK_ENABLE)
  ) u_lock (
    .now_i        (now),
    .sep_i        (separation),
    .sep_known_i  (in_user_q[2]),
    .valid_one_i  (valid_one),
    .valid_two_i  (valid_two),
    .lock_enter_i (cfg_q.lock_enter),
    .lock_exit_i  (cfg_q.lock_exit),
    .cur_i        (lock_q),
    .nxt_o        (lock_d),
    .release_o    (released)
  );

  // A lock release restarts the switch timer before the path decision sees it
  always_comb begin
    sel_mid = sel_q;
    if (released) begin
      sel_mid.switch_time = now;
    end
  end

  hts_choice #(
    .CONFIRM_SWITCH (CONFIRM_SWITCH)
  ) u_choice (
    .now_i        (now),
    .dist_one_i   (dist_one),
    .dist_two_i   (dist_two),
    .valid_one_i  (valid_one),
    .valid_two_i  (valid_two),
    .cfg_i        (cfg_q),
    .lock_i       (lock_d),
    .cur_i        (sel_mid),
    .nxt_o        (sel_d)
  );

  // Control state, state of the selector and registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q           <= 1'b0;
      out_valid_q          <= 1'b0;
      lock_q               <= '0;
      sel_q                <= '0;
      cfg_q.switch_margin  <= hts_pkg::RST_SWITCH_MARGIN;
      cfg_q.force_distance <= hts_pkg::RST_FORCE_DISTANCE;
      cfg_q.force_margin   <= hts_pkg::RST_FORCE_MARGIN;
      cfg_q.lock_enter     <= hts_pkg::RST_LOCK_ENTER;
      cfg_q.lock_exit      <= hts_pkg::RST_LOCK_EXIT;
      cfg_q.min_hold_ms    <= hts_pkg::RST_MIN_HOLD_MS;
      cfg_q.cooldown_ms    <= hts_pkg::RST_COOLDOWN_MS;
      cfg_q.unlock_hold_ms <= hts_pkg::RST_UNLOCK_HOLD_MS;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end

      if (advance) begin
        out_valid_q <= 1'b1;
        lock_q      <= lock_d;
        sel_q       <= sel_d;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          hts_pkg::REG_SWITCH_MARGIN:  cfg_q.switch_margin  <= cfg_data_i;
          hts_pkg::REG_FORCE_DISTANCE: cfg_q.force_distance <= cfg_data_i;
          hts_pkg::REG_FORCE_MARGIN:   cfg_q.force_margin   <= cfg_data_i;
          hts_pkg::REG_LOCK_ENTER:     cfg_q.lock_enter     <= cfg_data_i;
          hts_pkg::REG_LOCK_EXIT:      cfg_q.lock_exit      <= cfg_data_i;
          hts_pkg::REG_MIN_HOLD_MS:    cfg_q.min_hold_ms    <= cfg_data_i;
          hts_pkg::REG_COOLDOWN_MS:    cfg_q.cooldown_ms    <= cfg_data_i;
          hts_pkg::REG_UNLOCK_HOLD_MS: cfg_q.unlock_hold_ms <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload: input frame and result fields
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_data_q <= s_axis_tdata_i;
      in_user_q <= s_axis_tuser_i;
    end
    if (advance) begin
      out_path_q   <= sel_d.stable;
      out_locked_q <= lock_d.flag;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_locked_q, out_path_q};

  // A delivered result always names a real path
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (out_path_q == hts_pkg::PATH_ONE || out_path_q == hts_pkg::PATH_TWO))
    else $error("result beat without a chosen path");

  // Once a frame has been processed, a path stays chosen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(advance) |-> (sel_q.stable != hts_pkg::PATH_NONE))
    else $error("selection lost after a frame");

  // Entry counter is idle while locked, exit counter is idle while unlocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lock_q.flag |-> (lock_q.enter_cnt == 4'd0))
    else $error("enter counter running while locked");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !lock_q.flag |-> (lock_q.exit_cnt == 4'd0))
    else $error("exit counter running while unlocked");

  // A pending count always belongs to a pending path
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sel_q.pend_cnt != 4'd0) |-> (sel_q.pend_choice != hts_pkg::PATH_NONE))
    else $error("pending count without a pending path");

endmodule

`default_nettype wire

// ===== design/hts_lock.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hts_lock #(
  parameter int CONFIRM_ENTER = 3,
  parameter int CONFIRM_EXIT  = 10,
  parameter int LOCK_ENABLE   = 1
) (
  input  wire logic [31:0]       now_i,
  input  wire logic [15:0]       sep_i,
  input  wire logic              sep_known_i,
  input  wire logic              valid_one_i,
  input  wire logic              valid_two_i,
  input  wire logic [15:0]       lock_enter_i,
  input  wire logic [15:0]       lock_exit_i,
  input  wire hts_pkg::hts_lock_t cur_i,
  output hts_pkg::hts_lock_t     nxt_o,
  output logic                   release_o
);

  localparam logic [3:0] NEED_ENTER = (CONFIRM_ENTER < 1) ? 4'd1 : 4'(CONFIRM_ENTER);
  localparam logic [3:0] NEED_EXIT  = (CONFIRM_EXIT < 1) ? 4'd1 : 4'(CONFIRM_EXIT);

  logic       ready;
  logic [3:0] enter_inc;
  logic [3:0] exit_inc;

  assign ready = (LOCK_ENABLE != 0) && valid_one_i && valid_two_i && sep_known_i;

  assign enter_inc = cur_i.enter_cnt +
                     4'((cur_i.enter_cnt < NEED_ENTER) && (cur_i.enter_cnt != hts_pkg::CNT_MAX));
  assign exit_inc  = cur_i.exit_cnt +
                     4'((cur_i.exit_cnt < NEED_EXIT) && (cur_i.exit_cnt != hts_pkg::CNT_MAX));

  always_comb begin
    nxt_o     = cur_i;
    release_o = 1'b0;
    if (!ready) begin
      nxt_o.flag       = 1'b0;
      nxt_o.enter_cnt  = '0;
      nxt_o.exit_cnt   = '0;
      nxt_o.unlock_set = 1'b0;
    end else if (!cur_i.flag) begin
      if (sep_i < lock_enter_i) begin
        nxt_o.enter_cnt = enter_inc;
        if ((enter_inc >= NEED_ENTER) || (enter_inc == hts_pkg::CNT_MAX)) begin
          nxt_o.flag       = 1'b1;
          nxt_o.enter_cnt  = '0;
          nxt_o.exit_cnt   = '0;
          nxt_o.unlock_set = 1'b0;
        end
      end else begin
        nxt_o.enter_cnt = '0;
      end
    end else begin
      if (sep_i > lock_exit_i) begin
        nxt_o.exit_cnt = exit_inc;
        if ((exit_inc >= NEED_EXIT) || (exit_inc == hts_pkg::CNT_MAX)) begin
          nxt_o.flag        = 1'b0;
          nxt_o.exit_cnt    = '0;
          nxt_o.enter_cnt   = '0;
          nxt_o.unlock_time = now_i;
          nxt_o.unlock_set  = 1'b1;
          release_o         = 1'b1;
        end
      end else begin
        nxt_o.exit_cnt = '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/hts_choice.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hts_choice #(
  parameter int CONFIRM_SWITCH = 3
) (
  input  wire logic [31:0]        now_i,
  input  wire logic [15:0]        dist_one_i,
  input  wire logic [15:0]        dist_two_i,
  input  wire logic               valid_one_i,
  input  wire logic               valid_two_i,
  input  wire hts_pkg::hts_cfg_t  cfg_i,
  input  wire hts_pkg::hts_lock_t lock_i,
  input  wire hts_pkg::hts_sel_t  cur_i,
  output hts_pkg::hts_sel_t       nxt_o
);

  localparam logic [3:0] NEED_SWITCH = (CONFIRM_SWITCH < 1) ? 4'd1 : 4'(CONFIRM_SWITCH);

  logic [1:0]  other;
  logic [15:0] dist_cur;
  logic [15:0] dist_oth;
  logic        force_sw;
  logic        margin_sw;
  logic        hold_ok;
  logic        unlock_hold;
  logic [3:0]  pend_inc;
  logic [31:0] since_unlock;
  logic [31:0] since_switch;

  assign other    = (cur_i.stable == hts_pkg::PATH_ONE) ? hts_pkg::PATH_TWO : hts_pkg::PATH_ONE;
  assign dist_cur = (cur_i.stable == hts_pkg::PATH_ONE) ? dist_one_i : dist_two_i;
  assign dist_oth = (cur_i.stable == hts_pkg::PATH_ONE) ? dist_two_i : dist_one_i;

  // Sums at 17 bits so they never wrap
  assign force_sw  = (dist_cur > cfg_i.force_distance) ||
                     (({1'b0, dist_oth} + {1'b0, cfg_i.force_margin}) < {1'b0, dist_cur});
  assign margin_sw = ({1'b0, dist_oth} + {1'b0, cfg_i.switch_margin}) < {1'b0, dist_cur};

  assign since_switch = now_i - cur_i.switch_time;
  assign since_unlock = now_i - lock_i.unlock_time;
  assign hold_ok      = since_switch >= {16'd0, cfg_i.min_hold_ms};
  assign unlock_hold  = !lock_i.flag && (cfg_i.unlock_hold_ms != 16'd0) && lock_i.unlock_set &&
                        (since_unlock < {16'd0, cfg_i.unlock_hold_ms});

  assign pend_inc = cur_i.pend_cnt + 4'(cur_i.pend_cnt != hts_pkg::CNT_MAX);

  always_comb begin
    logic [1:0]  decided;
    logic        skip_cool;
    logic [31:0] since_new;
    decided   = cur_i.stable;
    skip_cool = 1'b0;
    since_new = '0;
    nxt_o     = cur_i;
    if ((cur_i.stable != hts_pkg::PATH_ONE) && (cur_i.stable != hts_pkg::PATH_TWO)) begin
      // First frame: take the nearer valid path, path one on a tie or with none valid
      if (valid_one_i && valid_two_i) begin
        nxt_o.stable = (dist_one_i <= dist_two_i) ? hts_pkg::PATH_ONE : hts_pkg::PATH_TWO;
      end else if (valid_two_i) begin
        nxt_o.stable = hts_pkg::PATH_TWO;
      end else begin
        nxt_o.stable = hts_pkg::PATH_ONE;
      end
      nxt_o.switch_time = now_i;
      skip_cool         = 1'b1;
    end else begin
      if (!valid_one_i && valid_two_i) begin
        decided = hts_pkg::PATH_TWO;
      end else if (valid_one_i && !valid_two_i) begin
        decided = hts_pkg::PATH_ONE;
      end else if (valid_one_i && valid_two_i) begin
        if (unlock_hold) begin
          nxt_o.pend_choice = hts_pkg::PATH_NONE;
          nxt_o.pend_cnt    = '0;
          skip_cool         = 1'b1;
        end else if (force_sw) begin
          decided = other;
        end else if (!lock_i.flag) begin
          if (margin_sw && hold_ok) begin
            if (cur_i.pend_choice == other) begin
              nxt_o.pend_cnt = pend_inc;
            end else begin
              nxt_o.pend_choice = other;
              nxt_o.pend_cnt    = 4'd1;
            end
            if ((nxt_o.pend_cnt >= NEED_SWITCH) || (nxt_o.pend_cnt == hts_pkg::CNT_MAX)) begin
              decided = other;
            end
          end else begin
            nxt_o.pend_choice = hts_pkg::PATH_NONE;
            nxt_o.pend_cnt    = '0;
          end
        end
      end
      if (!skip_cool) begin
        if (decided != cur_i.stable) begin
          nxt_o.stable      = decided;
          nxt_o.switch_time = now_i;
          nxt_o.pend_choice = hts_pkg::PATH_NONE;
          nxt_o.pend_cnt    = '0;
        end
        // Cooldown: drop any pending switch shortly after a switch while unlocked
        since_new = now_i - nxt_o.switch_time;
        if (!lock_i.flag && (since_new < {16'd0, cfg_i.cooldown_ms})) begin
          nxt_o.pend_choice = hts_pkg::PATH_NONE;
          nxt_o.pend_cnt    = '0;
        end
      end
    end
  end

endmodule

`default_nettype wire
